/* rtl/srv6_routing_header_inserter_macros.svh */
// ---------------------------------------------------------------------------
// SRv6 routing header inserter: assertion macros
// Immediate-implication and next-cycle checks, sampled on clock, off in reset.
// ---------------------------------------------------------------------------
`ifndef SRV6_ROUTING_HEADER_INSERTER_MACROS_SVH
`define SRV6_ROUTING_HEADER_INSERTER_MACROS_SVH

// cons must hold in the same cycle as ante
`define SRV6RH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define SRV6RH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/srv6rh_pkg.sv */
// ---------------------------------------------------------------------------
// srv6rh_pkg
// Types and constants shared by the SRv6 routing header inserter.
// ---------------------------------------------------------------------------
package srv6rh_pkg;

   localparam int WORD_W = 64;
   localparam int VB_W   = 4;
   localparam int SLOT_W = 4;
   localparam int CNT_W  = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;
   localparam int HDR_AW = 3;
   localparam int HDR_DEPTH = 5;
   localparam int STEP_W = 6;
   localparam int N_W    = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENCAP_DEST   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDR_COUNT   = 1'b1;

   localparam logic [2:0]      HDR_WORDS        = 3'd5;
   localparam logic [VB_W-1:0] FULL_WORD_BYTES  = 4'd8;
   localparam logic [7:0]      NEXT_HDR_ROUTING = 8'd43;
   localparam logic [7:0]      SRH_TYPE_SEG     = 8'd4;
   localparam logic [15:0]     SRH_FIXED_BYTES  = 16'd8;
   localparam logic [HDR_AW-1:0] HDR_DEST_HI    = 3'd3;

   // emission steps in insert mode
   localparam logic [STEP_W-1:0] STEP_HDR0       = 6'd0;
   localparam logic [STEP_W-1:0] STEP_HDR2       = 6'd2;
   localparam logic [STEP_W-1:0] STEP_DEST_HI    = 6'd3;
   localparam logic [STEP_W-1:0] STEP_DEST_LO    = 6'd4;
   localparam logic [STEP_W-1:0] STEP_SRH        = 6'd5;
   localparam logic [STEP_W-1:0] STEP_LIST_BASE  = 6'd6;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_BODY,
      ST_PRIME,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic           dump;
      logic           encap;
      logic [N_W-1:0] n;
   } fmt_ctl_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_word;
      logic              out_end_of_packet;
      logic [VB_W-1:0]   out_valid_bytes;
      logic              run_last;
      logic              header_error;
   } rsp_payload_type;

endpackage

/* rtl/srv6rh_req_if.sv */
// ---------------------------------------------------------------------------
// srv6rh_req_if
// Input channel: packet words and segment table writes.
// ---------------------------------------------------------------------------
interface srv6rh_req_if
   import srv6rh_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                command;
   logic [WORD_W-1:0]   data_word;
   logic                end_of_packet;
   logic [VB_W-1:0]     valid_bytes;
   logic [SLOT_W-1:0]   table_slot;

   modport source (
      output valid, command, data_word, end_of_packet, valid_bytes, table_slot,
      input  ready
   );
   modport sink (
      input  valid, command, data_word, end_of_packet, valid_bytes, table_slot,
      output ready
   );
endinterface

/* rtl/srv6rh_rsp_if.sv */
// ---------------------------------------------------------------------------
// srv6rh_rsp_if
// Result channel: output packet words.
// ---------------------------------------------------------------------------
interface srv6rh_rsp_if
   import srv6rh_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   out_word;
   logic                out_end_of_packet;
   logic [VB_W-1:0]     out_valid_bytes;
   logic                run_last;
   logic                header_error;

   modport source (
      output valid, out_word, out_end_of_packet, out_valid_bytes, run_last, header_error,
      input  ready
   );
   modport sink (
      input  valid, out_word, out_end_of_packet, out_valid_bytes, run_last, header_error,
      output ready
   );
endinterface

/* rtl/srv6rh_csr_if.sv */
// ---------------------------------------------------------------------------
// srv6rh_csr_if
// Configuration write channel.
// ---------------------------------------------------------------------------
interface srv6rh_csr_if
   import srv6rh_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* rtl/srv6rh_ram.sv */
// ---------------------------------------------------------------------------
// srv6rh_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module srv6rh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/srv6rh_fmt.sv */
// ---------------------------------------------------------------------------
// srv6rh_fmt
// Emission step decoder: RAM read addresses for the upcoming step and the
// output word for the current step from the registered RAM data.
// ---------------------------------------------------------------------------
module srv6rh_fmt
   import srv6rh_pkg::*;
#(
   parameter int MAX_ADDRESSES = 8,
   parameter int TW = $clog2(2 * MAX_ADDRESSES)
) (
   input  fmt_ctl_type         ctl,
   input  logic [STEP_W-1:0]   rd_step,
   input  logic [STEP_W-1:0]   cur_step,
   input  logic [WORD_W-1:0]   hdr_rdata,
   input  logic [WORD_W-1:0]   tbl_rdata,
   output logic [HDR_AW-1:0]   hdr_raddr,
   output logic [TW-1:0]       tbl_raddr,
   output logic [WORD_W-1:0]   word
);

   typedef struct packed {
      logic              is_entry;
      logic              from_hdr;
      logic              half;
      logic [STEP_W-1:0] tbl_idx;
   } entry_type;

   // segment entry addressed by an emission step
   function automatic entry_type decode_entry(input logic [STEP_W-1:0] s,
                                              input fmt_ctl_type c);
      entry_type         r;
      logic [N_W-1:0]    e;
      logic [STEP_W-1:0] rel;
      rel = s - STEP_LIST_BASE;
      if (s == STEP_DEST_HI || s == STEP_DEST_LO) begin
         e      = c.n - N_W'(1);
         r.half = (s == STEP_DEST_LO);
      end else begin
         e      = rel[N_W:1];
         r.half = s[0];
      end
      r.is_entry = (s == STEP_DEST_HI) || (s == STEP_DEST_LO) || (s >= STEP_LIST_BASE);
      r.from_hdr = c.encap && (e == '0);
      r.tbl_idx  = {e - N_W'(c.encap), r.half};
      return r;
   endfunction

   entry_type rd_ent;
   entry_type cur_ent;
   logic [15:0] plen;
   logic [7:0]  n8;

   always_comb begin
      rd_ent  = decode_entry(rd_step, ctl);
      cur_ent = decode_entry(cur_step, ctl);
      n8      = {3'b0, ctl.n};
      plen    = hdr_rdata[31:16] + SRH_FIXED_BYTES + {7'b0, ctl.n, 4'b0};
   end

   always_comb begin
      tbl_raddr = TW'(rd_ent.tbl_idx);
      if (ctl.dump || rd_step <= STEP_HDR2) begin
         hdr_raddr = rd_step[HDR_AW-1:0];
      end else if (rd_step == STEP_SRH) begin
         hdr_raddr = STEP_HDR0[HDR_AW-1:0];
      end else begin
         hdr_raddr = HDR_DEST_HI + HDR_AW'(rd_ent.half);
      end
   end

   always_comb begin
      if (ctl.dump) begin
         word = hdr_rdata;
      end else if (cur_step == STEP_HDR0) begin
         word = {hdr_rdata[63:32], plen, NEXT_HDR_ROUTING, hdr_rdata[7:0]};
      end else if (cur_step == STEP_SRH) begin
         word = {hdr_rdata[15:8], {n8[6:0], 1'b0}, SRH_TYPE_SEG,
                 n8 - 8'd1, n8 - 8'd1, 24'b0};
      end else if (cur_ent.is_entry && !cur_ent.from_hdr) begin
         word = tbl_rdata;
      end else begin
         word = hdr_rdata;
      end
   end

endmodule

/* rtl/srv6_routing_header_inserter.sv */
// ---------------------------------------------------------------------------
// srv6_routing_header_inserter
// Inserts a segment routing header after the IPv6 fixed header of each
// packet, rewriting payload length, next header and destination.
// ---------------------------------------------------------------------------
// Channels: req_chan carries packet words (command 0) and segment table
// writes (command 1, table_slot = address * 2 + half, high half first);
// rsp_chan carries output words; csr_chan writes encap_destination (0) and
// address_count (1) and is always ready.
// Header words 0..4 are stored in a header RAM and produce nothing when
// taken. After the fifth word the block stalls the input and emits
// 6 + 2n words (n segment entries): a priming state, then one word per
// cycle while the receiver keeps up, from the registered RAM read ports.
// Short packets and an empty list are replayed from the header RAM with
// header_error set. Body words then pass through the output register, one
// per cycle while the receiver keeps up. Table writes give no result.
// Output is a single register: the input is taken only when that register
// is free or is drained in the same cycle, so a stalled receiver stalls
// the input. Reset clears control state and the configuration (encap on,
// count zero); the RAMs hold no reset value and need no clearing.
// ---------------------------------------------------------------------------
module srv6_routing_header_inserter
   import srv6rh_pkg::*;
#(
   parameter int MAX_ADDRESSES = 8
) (
   input  logic             clock,
   input  logic             reset,
   srv6rh_req_if.sink       req_chan,
   srv6rh_rsp_if.source     rsp_chan,
   srv6rh_csr_if.sink       csr_chan
);

   `include "srv6_routing_header_inserter_macros.svh"

   localparam int TBL_DEPTH = 2 * MAX_ADDRESSES;
   localparam int TW = $clog2(TBL_DEPTH);

   state_type       state_ff, state_in;
   logic [2:0]      count_ff, count_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic            dump_ff, dump_in;
   logic [2:0]      len_ff, len_in;
   logic            eop_ff, eop_in;
   logic [VB_W-1:0] vb_ff, vb_in;
   logic            pass_ff, pass_in;
   logic            encap_ff;
   logic [CNT_W-1:0] addr_cnt_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   logic            req_fire, data_fire, tbl_fire, out_free, emit_fire, emit_last;
   logic [VB_W-1:0] vb_eff;
   logic [2:0]      cnt_next;
   logic            short_pkt;
   logic [CNT_W-1:0] cnt_sat;
   logic [N_W-1:0]  n;
   logic [STEP_W-1:0] last_step;

   logic              hdr_we;
   logic [HDR_AW-1:0] hdr_raddr;
   logic [WORD_W-1:0] hdr_rdata;
   logic              tbl_we;
   logic [TW-1:0]     tbl_raddr;
   logic [WORD_W-1:0] tbl_rdata;
   logic [WORD_W-1:0] emit_word;
   fmt_ctl_type       fmt_ctl;

   // ---------------- configuration ----------------
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         encap_ff    <= 1'b1;
         addr_cnt_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            CSR_ENCAP_DEST: encap_ff    <= csr_chan.wdata[0];
            CSR_ADDR_COUNT: addr_cnt_ff <= csr_chan.wdata[CNT_W-1:0];
            default:        encap_ff    <= encap_ff;
         endcase
      end
   end

   // ---------------- decode ----------------
   always_comb begin
      out_free  = !out_valid_ff || rsp_chan.ready;
      req_fire  = req_chan.valid && req_chan.ready;
      data_fire = req_fire && !req_chan.command;
      tbl_fire  = req_fire && req_chan.command;
      vb_eff    = (req_chan.valid_bytes == '0 || req_chan.valid_bytes > FULL_WORD_BYTES)
                  ? FULL_WORD_BYTES : req_chan.valid_bytes;
      cnt_next  = count_ff + 3'd1;
      short_pkt = req_chan.end_of_packet && (cnt_next < HDR_WORDS || vb_eff < FULL_WORD_BYTES);
      cnt_sat   = (int'(addr_cnt_ff) > MAX_ADDRESSES) ? CNT_W'(MAX_ADDRESSES) : addr_cnt_ff;
      n         = {1'b0, cnt_sat} + N_W'(encap_ff);
      last_step = dump_ff ? STEP_W'(len_ff - 3'd1) : ({n, 1'b0} + STEP_SRH);
      emit_fire = (state_ff == ST_EMIT) && out_free;
      emit_last = (step_ff == last_step);
      fmt_ctl   = '{dump: dump_ff, encap: encap_ff, n: n};
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (data_fire && (short_pkt || cnt_next == HDR_WORDS)) begin
               state_in = ST_PRIME;
            end
         end
         ST_BODY: begin
            if (data_fire && req_chan.end_of_packet) begin
               state_in = ST_COLLECT;
            end
         end
         ST_PRIME: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_fire && emit_last) begin
               state_in = eop_ff ? ST_COLLECT : ST_BODY;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // ---------------- datapath control ----------------
   always_comb begin
      req_chan.ready = ((state_ff == ST_COLLECT) || (state_ff == ST_BODY)) && out_free;
      count_in     = count_ff;
      step_in      = '0;
      dump_in      = dump_ff;
      len_in       = len_ff;
      eop_in       = eop_ff;
      vb_in        = vb_ff;
      pass_in      = pass_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      hdr_we       = 1'b0;
      tbl_we       = tbl_fire && (int'(req_chan.table_slot) < TBL_DEPTH);

      unique case (state_ff)
         ST_COLLECT: begin
            if (data_fire) begin
               hdr_we = 1'b1;
               eop_in = req_chan.end_of_packet;
               vb_in  = vb_eff;
               priority if (short_pkt) begin
                  dump_in  = 1'b1;
                  len_in   = cnt_next;
                  count_in = '0;
               end else if (cnt_next == HDR_WORDS) begin
                  dump_in  = (n == '0);
                  len_in   = HDR_WORDS;
                  count_in = '0;
               end else begin
                  count_in = cnt_next;
               end
            end
         end
         ST_BODY: begin
            if (data_fire) begin
               out_valid_in = 1'b1;
               out_in = '{out_word:          req_chan.data_word,
                          out_end_of_packet: req_chan.end_of_packet,
                          out_valid_bytes:   req_chan.end_of_packet ? vb_eff : FULL_WORD_BYTES,
                          run_last:          1'b1,
                          header_error:      pass_ff};
               if (req_chan.end_of_packet) begin
                  pass_in = 1'b0;
               end
            end
         end
         ST_PRIME: step_in = '0;
         ST_EMIT: begin
            step_in = step_ff;
            if (emit_fire) begin
               out_valid_in = 1'b1;
               out_in = '{out_word:          emit_word,
                          out_end_of_packet: emit_last && eop_ff,
                          out_valid_bytes:   (emit_last && eop_ff && dump_ff)
                                             ? vb_ff : FULL_WORD_BYTES,
                          run_last:          emit_last,
                          header_error:      dump_ff};
               if (emit_last) begin
                  step_in = '0;
                  pass_in = dump_ff && !eop_ff;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         default: step_in = '0;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         count_ff     <= '0;
         step_ff      <= '0;
         pass_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dump_ff <= dump_in;
      len_ff  <= len_in;
      eop_ff  <= eop_in;
      vb_ff   <= vb_in;
      out_ff  <= out_in;
   end

   // ---------------- memories and formatter ----------------
   srv6rh_ram #(
      .WIDTH (WORD_W),
      .DEPTH (HDR_DEPTH),
      .AW    (HDR_AW)
   ) u_hdr_ram (
      .clock (clock),
      .we    (hdr_we),
      .waddr (count_ff),
      .wdata (req_chan.data_word),
      .raddr (hdr_raddr),
      .rdata (hdr_rdata)
   );

   srv6rh_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TBL_DEPTH),
      .AW    (TW)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (TW'(req_chan.table_slot)),
      .wdata (req_chan.data_word),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   srv6rh_fmt #(
      .MAX_ADDRESSES (MAX_ADDRESSES),
      .TW            (TW)
   ) u_fmt (
      .ctl       (fmt_ctl),
      .rd_step   (step_in),
      .cur_step  (step_ff),
      .hdr_rdata (hdr_rdata),
      .tbl_rdata (tbl_rdata),
      .hdr_raddr (hdr_raddr),
      .tbl_raddr (tbl_raddr),
      .word      (emit_word)
   );

   // ---------------- outputs ----------------
   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.out_word          = out_ff.out_word;
   assign rsp_chan.out_end_of_packet = out_ff.out_end_of_packet;
   assign rsp_chan.out_valid_bytes   = out_ff.out_valid_bytes;
   assign rsp_chan.run_last          = out_ff.run_last;
   assign rsp_chan.header_error      = out_ff.header_error;

   // ---------------- assertions ----------------
   `SRV6RH_ASSERT_NEXT(a_prime_then_emit, state_ff == ST_PRIME, state_ff == ST_EMIT, "prime not followed by emit")
   `SRV6RH_ASSERT_NOW(a_count_range, state_ff == ST_COLLECT, count_ff < HDR_WORDS, "header count overrun")
   `SRV6RH_ASSERT_NOW(a_step_range, state_ff == ST_EMIT, step_ff <= last_step, "emission step overrun")
   `SRV6RH_ASSERT_NEXT(a_emit_ends, emit_fire && emit_last, state_ff != ST_EMIT && rsp_chan.valid && rsp_chan.run_last, "emission did not end on last word")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRv6 routing header inserter testbench
// Feeds IPv6 packet words and segment table writes into the inserter and
// predicts every output word from a shadow of the block's state: header
// rewrite, SRH word, segment list, body pass-through, runts and empty lists.
// Output words are checked in order, field by field, while both channels
// idle at random. Several encap/count settings are swept between phases.
// ----------------------------------------------------------------------------
module testbench
   import srv6rh_pkg::*;
();

   localparam logic       CMD_PACKET    = 1'b0;
   localparam logic       CMD_TABLE     = 1'b1;
   localparam int         TABLE_WORDS   = 16;
   localparam int         MAX_ADDR      = 8;
   localparam logic [7:0] NH_ROUTING    = 8'd43;
   localparam logic [7:0] SRH_TYPE      = 8'd4;
   localparam int         SETTLE_CYCLES = 32;
   localparam int         HOLD_CYCLES   = 120;
   localparam int         PHASE_ITEMS   = 18;
   localparam int         NUM_PHASES    = 9;

   typedef struct packed {
      logic              command;
      logic [WORD_W-1:0] data_word;
      logic              end_of_packet;
      logic [VB_W-1:0]   valid_bytes;
      logic [SLOT_W-1:0] table_slot;
   } word_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   drv_valid = 1'b0;
   word_item_type          drv_item  = '0;
   logic                   rsp_ready = 1'b0;
   logic                   csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   int   send_idle = 0;
   int   recv_idle = 0;
   logic hold_arm  = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;
   int   err_count = 0;

   word_item_type   pending_words[$];
   rsp_payload_type predicted_words[$];

   // shadow of the inserter's state and configuration
   logic [WORD_W-1:0] hdr_buf   [HDR_DEPTH];
   logic [WORD_W-1:0] seg_table [TABLE_WORDS];
   int unsigned       hdr_fill  = 0;
   logic              body_err  = 1'b0;
   logic              cfg_encap = 1'b1;
   logic [CNT_W-1:0]  cfg_count = '0;

   srv6rh_req_if req_if ();
   srv6rh_rsp_if rsp_if ();
   srv6rh_csr_if csr_if ();

   assign req_if.valid         = drv_valid;
   assign req_if.command       = drv_item.command;
   assign req_if.data_word     = drv_item.data_word;
   assign req_if.end_of_packet = drv_item.end_of_packet;
   assign req_if.valid_bytes   = drv_item.valid_bytes;
   assign req_if.table_slot    = drv_item.table_slot;
   assign rsp_if.ready         = rsp_ready;
   assign csr_if.valid         = csr_valid;
   assign csr_if.reg_index     = csr_index;
   assign csr_if.wdata         = csr_data;

   srv6_routing_header_inserter u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [VB_W-1:0] eff_bytes(logic [VB_W-1:0] vb);
      return (vb == 4'd0 || vb > FULL_WORD_BYTES) ? FULL_WORD_BYTES : vb;
   endfunction

   function automatic void push_word(logic [WORD_W-1:0] w, logic eop, logic [VB_W-1:0] vb,
                                     logic err, logic last);
      rsp_payload_type r;
      r.out_word          = w;
      r.out_end_of_packet = eop;
      r.out_valid_bytes   = vb;
      r.run_last          = last;
      r.header_error      = err;
      predicted_words.push_back(r);
   endfunction

   // with encap on, entry 0 is the original destination and table address i is entry i+1
   function automatic logic [WORD_W-1:0] entry_half(int unsigned entry, int unsigned half);
      int unsigned e = entry;
      if (cfg_encap) begin
         if (e == 0)
            return hdr_buf[3 + half];
         e = e - 1;
      end
      return seg_table[e * 2 + half];
   endfunction

   task automatic predict_output(input word_item_type it);
      logic [VB_W-1:0]   vb;
      int unsigned       cnt;
      int unsigned       n;
      logic [15:0]       plen;
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] srh;
      logic              last;
      logic              eop;
      vb  = eff_bytes(it.valid_bytes);
      eop = it.end_of_packet;
      if (it.command == CMD_TABLE) begin
         seg_table[it.table_slot] = it.data_word;
         return;
      end
      if (hdr_fill >= HDR_DEPTH) begin
         push_word(it.data_word, eop, eop ? vb : FULL_WORD_BYTES, body_err, 1'b1);
         if (eop) begin
            hdr_fill = 0;
            body_err = 1'b0;
         end
         return;
      end
      hdr_buf[hdr_fill] = it.data_word;
      hdr_fill++;
      // packet ended before the 40 header bytes: replay it flagged
      if (eop && (hdr_fill < HDR_DEPTH || vb < FULL_WORD_BYTES)) begin
         for (int i = 0; i < hdr_fill; i++) begin
            last = (i + 1 == hdr_fill);
            push_word(hdr_buf[i], last, last ? vb : FULL_WORD_BYTES, 1'b1, last);
         end
         hdr_fill = 0;
         body_err = 1'b0;
         return;
      end
      if (hdr_fill < HDR_DEPTH)
         return;
      cnt = (cfg_count > MAX_ADDR) ? MAX_ADDR : cfg_count;
      n   = cnt + cfg_encap;
      if (n == 0) begin
         // empty list: header goes out unchanged, flagged, and so does the body
         for (int i = 0; i < HDR_DEPTH; i++) begin
            last = (i == HDR_DEPTH - 1);
            push_word(hdr_buf[i], last && eop, (last && eop) ? vb : FULL_WORD_BYTES, 1'b1,
                      last);
         end
         body_err = !eop;
      end else begin
         plen = hdr_buf[0][31:16] + 16'd8 + 16'(16 * n);
         w0   = {hdr_buf[0][63:32], plen, NH_ROUTING, hdr_buf[0][7:0]};
         srh  = {hdr_buf[0][15:8], 8'(2 * n), SRH_TYPE, 8'(n - 1), 8'(n - 1), 24'd0};
         push_word(w0, 1'b0, FULL_WORD_BYTES, 1'b0, 1'b0);
         push_word(hdr_buf[1], 1'b0, FULL_WORD_BYTES, 1'b0, 1'b0);
         push_word(hdr_buf[2], 1'b0, FULL_WORD_BYTES, 1'b0, 1'b0);
         push_word(entry_half(n - 1, 0), 1'b0, FULL_WORD_BYTES, 1'b0, 1'b0);
         push_word(entry_half(n - 1, 1), 1'b0, FULL_WORD_BYTES, 1'b0, 1'b0);
         push_word(srh, 1'b0, FULL_WORD_BYTES, 1'b0, 1'b0);
         for (int unsigned e = 0; e < n; e++) begin
            last = (e + 1 == n);
            push_word(entry_half(e, 0), 1'b0, FULL_WORD_BYTES, 1'b0, 1'b0);
            push_word(entry_half(e, 1), last && eop, FULL_WORD_BYTES, 1'b0, last);
         end
         body_err = 1'b0;
      end
      hdr_fill = eop ? 0 : HDR_DEPTH;
   endtask

   // noisy packets get random byte counts on inner words and stray table writes
   function automatic void queue_packet(int len, logic [VB_W-1:0] last_vb, logic [15:0] plen,
                                        logic noisy);
      word_item_type it;
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            it.command       = CMD_TABLE;
            it.data_word     = {$urandom, $urandom};
            it.end_of_packet = 1'($urandom);
            it.valid_bytes   = 4'($urandom);
            it.table_slot    = 4'($urandom);
            pending_words.push_back(it);
         end
         it.command   = CMD_PACKET;
         it.data_word = {$urandom, $urandom};
         if (i == 0)
            it.data_word[31:16] = plen;
         it.end_of_packet = (i == len - 1);
         if (it.end_of_packet)
            it.valid_bytes = last_vb;
         else
            it.valid_bytes = (noisy && $urandom_range(0, 2) == 0) ? 4'($urandom)
                                                                   : FULL_WORD_BYTES;
         it.table_slot = 4'($urandom);
         pending_words.push_back(it);
      end
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || drv_valid || predicted_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic encap, logic [CNT_W-1:0] count);
      csr_index <= CSR_ENCAP_DEST;
      csr_data  <= CSR_DATA_W'(encap);
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_index <= CSR_ADDR_COUNT;
      csr_data  <= count;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_valid <= 1'b0;
   endtask

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         err_count++;
      end
   endfunction

   // sender: holds an item until it is taken, then maybe idles
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_if.ready)
            predict_output(drv_item);
         if (!drv_valid || req_if.ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               drv_valid <= 1'b1;
               drv_item  <= pending_words.pop_front();
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off while the sender keeps offering
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
      else if (hold_arm && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && csr_valid && csr_if.ready) begin
         case (csr_index)
            CSR_ENCAP_DEST: cfg_encap = csr_data[0];
            CSR_ADDR_COUNT: cfg_count = csr_data;
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_ready) begin
         if (predicted_words.size() == 0) begin
            $error("unexpected output word %h", rsp_if.out_word);
            err_count++;
         end else begin
            want = predicted_words.pop_front();
            check_field("out_word", want.out_word, rsp_if.out_word);
            check_field("out_end_of_packet", want.out_end_of_packet,
                        rsp_if.out_end_of_packet);
            check_field("out_valid_bytes", want.out_valid_bytes, rsp_if.out_valid_bytes);
            check_field("run_last", want.run_last, rsp_if.run_last);
            check_field("header_error", want.header_error, rsp_if.header_error);
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic             phase_encap [NUM_PHASES];
      logic [CNT_W-1:0] phase_count [NUM_PHASES];
      word_item_type    tw;
      int               queued;
      int               len;
      int               r;
      logic [VB_W-1:0]  lvb;
      logic [15:0]      plen;
      phase_encap = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      phase_count = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd0, 4'd15, 4'd8, 4'd0, 4'd0};
      phase_count[7] = 4'($urandom_range(0, 15));
      phase_count[8] = 4'($urandom_range(0, 15));

      repeat (2) @(posedge clock);
      reset     <= 1'b0;
      send_idle <= 21;
      recv_idle <= 49;

      // out of reset: encap on, no table addresses, so one entry
      queue_packet(5, 4'd8, 16'hFFF0, 1'b0);   // exactly 40 bytes, length wraps
      queue_packet(1, 4'd0, 16'h0000, 1'b0);   // one-word runt, zero byte count
      queue_packet(5, 4'd4, 16'h1234, 1'b0);   // five words but header bytes short
      for (int s = 0; s < TABLE_WORDS; s++) begin
         tw.command       = CMD_TABLE;
         tw.data_word     = {$urandom, $urandom};
         tw.end_of_packet = 1'b0;
         tw.valid_bytes   = FULL_WORD_BYTES;
         tw.table_slot    = 4'(s);
         pending_words.push_back(tw);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         if (p == 3) begin
            send_idle <= 49;
            recv_idle <= 21;
         end else if (p == 6) begin
            send_idle <= 0;
            recv_idle <= 0;
         end
         set_config(phase_encap[p], phase_count[p]);
         queued = 0;
         while (queued < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               len = $urandom_range(1, 5);
               lvb = (len == 5) ? 4'($urandom_range(1, 7)) : 4'($urandom);
            end else if (r < 35) begin
               len = 5;
               lvb = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
            end else begin
               len = $urandom_range(6, 12);
               lvb = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
            end
            plen = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(16'hFE00, 16'hFFFF))
                                               : 16'($urandom);
            queue_packet(len, lvb, plen, $urandom_range(0, 3) == 0);
            queued += len;
         end
         if (p == 6)
            hold_arm <= 1'b1;
      end

      wait_idle();
      if (err_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
